// File: sv/latency_histogram_percentiles_macros.svh
// Assertion macros shared by the latency histogram RTL.
`ifndef LATENCY_HISTOGRAM_PERCENTILES_MACROS_SVH
`define LATENCY_HISTOGRAM_PERCENTILES_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LHP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define LHP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/lhp_pkg.sv
// Constants for the latency histogram: bucket edges and rank divider counters.
package lhp_pkg;

    localparam int NUM_EDGES = 8;
    localparam int HIT_W     = 4;

    // Upper edges of the first eight buckets in nanoseconds.
    localparam logic [63:0] EDGE_NS [NUM_EDGES] = '{
        64'd50_000, 64'd100_000, 64'd250_000, 64'd500_000,
        64'd1_000_000, 64'd2_000_000, 64'd5_000_000, 64'd10_000_000
    };

    // Index of the edge that also floors the top bucket estimate.
    localparam int TOP_EDGE_IDX = NUM_EDGES - 1;

    // Running remainders for floor(n/20), floor(n/100) and floor(n/1000).
    localparam int REM20_W   = 5;
    localparam int REM100_W  = 7;
    localparam int REM1000_W = 10;
    localparam logic [REM20_W-1:0]   REM20_LAST   = 5'd19;
    localparam logic [REM100_W-1:0]  REM100_LAST  = 7'd99;
    localparam logic [REM1000_W-1:0] REM1000_LAST = 10'd999;

endpackage

// File: sv/latency_histogram_percentiles.sv
// Latency histogram with p50/p95/p99/p99.9 estimates, top level.
// Pipeline: an accepted input beat passes through the input register, the
// histogram update stage and the result register.
// Throughput: one beat per cycle while the output is not stalled; the cumulative
// bucket counters and the rank divider counters are updated in place, so no loop runs per sample.
// Reset (i_rst_n low, synchronous) clears all counters and the peak at once.
module latency_histogram_percentiles #(
    parameter int COUNT_WIDTH    = 32,
    parameter int DURATION_WIDTH = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // tdata: duration_ns [DURATION_WIDTH-1:0], zero padding above.
    input  logic [((DURATION_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // tdata from bit 0 up: bucket_hit (4), p50_ns, p95_ns, p99_ns, p999_ns,
    // peak_ns (DURATION_WIDTH each), samples_seen (COUNT_WIDTH), zero padding.
    output logic [((lhp_pkg::HIT_W+5*DURATION_WIDTH+COUNT_WIDTH+7)/8)*8-1:0]
                                 o_m_axis_tdata
);

    localparam int DW      = DURATION_WIDTH;
    localparam int CW      = COUNT_WIDTH;
    localparam int NE      = lhp_pkg::NUM_EDGES;
    localparam int HW      = lhp_pkg::HIT_W;
    localparam int OUT_RAW = HW + 5 * DW + CW;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
    localparam int NRANK   = 4;

    // Pipeline control.
    logic r_v0, r_v1, r_vo;
    logic out_en, s1_en, s1_load, s_accept;

    // Input register.
    logic [DW-1:0] r_dur;

    // Histogram state: cumulative counts below each edge, total, peak.
    logic [CW-1:0] r_cum [NE];
    logic [CW-1:0] r_total;
    logic [DW-1:0] r_hw;
    logic [CW-1:0] r_q20, r_q100, r_q1000;
    logic [lhp_pkg::REM20_W-1:0]   r_r20;
    logic [lhp_pkg::REM100_W-1:0]  r_r100;
    logic [lhp_pkg::REM1000_W-1:0] r_r1000;
    logic [HW-1:0] r_hit1;

    // Result register.
    logic [HW-1:0] r_out_hit;
    logic [DW-1:0] r_out_est [NRANK];
    logic [DW-1:0] r_out_peak;
    logic [CW-1:0] r_out_total;

    logic [HW-1:0] n_hit;
    logic          hit_found;
    logic          total_full;
    logic [CW-1:0] rank [NRANK];
    logic [DW-1:0] n_est [NRANK];
    logic [DW-1:0] top_est;
    logic [DW-1:0] top_edge;

    // Stall chain: each stage moves when empty or when its successor moves.
    assign out_en          = !r_vo || i_m_axis_tready;
    assign s1_en           = !r_v1 || out_en;
    assign s1_load         = r_v0 && s1_en;
    assign o_s_axis_tready = !r_v0 || s1_en;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Bin the registered sample: first edge that lies above it.
    always_comb begin
        n_hit     = HW'(NE);
        hit_found = 1'b0;
        for (int b = 0; b < NE; b++) begin
            if (!hit_found && r_dur < lhp_pkg::EDGE_NS[b][DW-1:0]) begin
                n_hit     = HW'(b);
                hit_found = 1'b1;
            end
        end
    end

    assign total_full = &r_total;

    // Ranks: ceil(n/2), and ceil(p*n) = n - floor((1-p)*n) for the others.
    assign rank[0] = (r_total >> 1) + CW'(r_total[0]);
    assign rank[1] = r_total - r_q20;
    assign rank[2] = r_total - r_q100;
    assign rank[3] = r_total - r_q1000;

    assign top_edge = lhp_pkg::EDGE_NS[lhp_pkg::TOP_EDGE_IDX][DW-1:0];
    assign top_est  = (r_hw > top_edge) ? r_hw : top_edge;

    // Percentile estimates: first edge whose running total reaches the rank.
    always_comb begin
        logic found;
        for (int k = 0; k < NRANK; k++) begin
            found    = 1'b0;
            n_est[k] = top_est;
            for (int b = 0; b < NE; b++) begin
                if (!found && rank[k] <= r_cum[b]) begin
                    n_est[k] = lhp_pkg::EDGE_NS[b][DW-1:0];
                    found    = 1'b1;
                end
            end
        end
    end

    // Registers for all three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_vo    <= 1'b0;
            r_total <= '0;
            r_hw    <= '0;
            r_q20   <= '0;
            r_q100  <= '0;
            r_q1000 <= '0;
            r_r20   <= '0;
            r_r100  <= '0;
            r_r1000 <= '0;
            for (int b = 0; b < NE; b++) begin
                r_cum[b] <= '0;
            end
        end else begin
            // Input register.
            if (s_accept) begin
                r_v0  <= 1'b1;
                r_dur <= i_s_axis_tdata[DW-1:0];
            end else if (s1_en) begin
                r_v0 <= 1'b0;
            end

            // Histogram update.
            if (s1_en) begin
                r_v1 <= r_v0;
            end
            if (s1_load) begin
                r_hit1 <= n_hit;
                if (r_dur > r_hw) begin
                    r_hw <= r_dur;
                end
                if (!total_full) begin
                    r_total <= r_total + 1'b1;
                    for (int b = 0; b < NE; b++) begin
                        if (n_hit <= HW'(b)) begin
                            r_cum[b] <= r_cum[b] + 1'b1;
                        end
                    end
                    if (r_r20 == lhp_pkg::REM20_LAST) begin
                        r_r20 <= '0;
                        r_q20 <= r_q20 + 1'b1;
                    end else begin
                        r_r20 <= r_r20 + 1'b1;
                    end
                    if (r_r100 == lhp_pkg::REM100_LAST) begin
                        r_r100 <= '0;
                        r_q100 <= r_q100 + 1'b1;
                    end else begin
                        r_r100 <= r_r100 + 1'b1;
                    end
                    if (r_r1000 == lhp_pkg::REM1000_LAST) begin
                        r_r1000 <= '0;
                        r_q1000 <= r_q1000 + 1'b1;
                    end else begin
                        r_r1000 <= r_r1000 + 1'b1;
                    end
                end
            end

            // Result register.
            if (out_en) begin
                r_vo <= r_v1;
            end
            if (out_en && r_v1) begin
                r_out_hit   <= r_hit1;
                r_out_peak  <= r_hw;
                r_out_total <= r_total;
                for (int k = 0; k < NRANK; k++) begin
                    r_out_est[k] <= n_est[k];
                end
            end
        end
    end

    assign o_m_axis_tvalid = r_vo;
    assign o_m_axis_tdata  = OUT_W'({r_out_total, r_out_peak, r_out_est[3], r_out_est[2],
                                     r_out_est[1], r_out_est[0], r_out_hit});

    `include "latency_histogram_percentiles_macros.svh"

    // The sample count never goes backward.
    `LHP_ASSERT_NEXT(a_total_mono, i_rst_n, r_total >= $past(r_total),
        "sample count decreased")
    // Divider remainders stay below their divisors.
    `LHP_ASSERT_NOW(a_rem_range, 1'b1,
        r_r20 <= lhp_pkg::REM20_LAST && r_r100 <= lhp_pkg::REM100_LAST &&
        r_r1000 <= lhp_pkg::REM1000_LAST, "rank remainder out of range")
    // Running totals never exceed the sample count.
    `LHP_ASSERT_NOW(a_cum_bound, 1'b1, r_cum[NE-1] <= r_total,
        "cumulative count above total")
    // A delivered result names a real bucket.
    `LHP_ASSERT_NOW(a_hit_range, r_vo, r_out_hit <= HW'(NE),
        "bucket index out of range")

endmodule
